/* rtl/cau_pkg.sv */
`default_nettype none
package cau_pkg;

  localparam int CAU_DATA_WIDTH = 32;
  localparam int CAU_FRAC_BITS  = 16;

  localparam int ACT_W     = 3;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 1;

  // operation codes
  localparam logic [ACT_W-1:0] ACT_MUL  = 3'd0;  // x*y
  localparam logic [ACT_W-1:0] ACT_DIV  = 3'd1;  // x/y
  localparam logic [ACT_W-1:0] ACT_MULC = 3'd2;  // x*c
  localparam logic [ACT_W-1:0] ACT_DIVC = 3'd3;  // x/c
  localparam logic [ACT_W-1:0] ACT_MAC  = 3'd4;  // x+y*c

  // result status codes
  localparam logic [ST_W-1:0] ST_OK  = 2'd0;
  localparam logic [ST_W-1:0] ST_SAT = 2'd1;
  localparam logic [ST_W-1:0] ST_DZ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CONST_RE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONST_IM = 1'b1;

  // operation class inside the pipe
  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_MUL  = 2'd1,
    CLS_DIV  = 2'd2,
    CLS_MAC  = 2'd3
  } cls_t;

endpackage
`default_nettype wire

/* rtl/cau_in_if.sv */
`default_nettype none
interface cau_in_if #(
  parameter int DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH
);
  import cau_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [ACT_W-1:0]             action;
  logic signed [DATA_WIDTH-1:0] x_re;
  logic signed [DATA_WIDTH-1:0] x_im;
  logic signed [DATA_WIDTH-1:0] y_re;
  logic signed [DATA_WIDTH-1:0] y_im;
  logic                         last_in;

  modport source (output valid, action, x_re, x_im, y_re, y_im, last_in, input ready);
  modport sink   (input valid, action, x_re, x_im, y_re, y_im, last_in, output ready);

endinterface
`default_nettype wire

/* rtl/cau_out_if.sv */
`default_nettype none
interface cau_out_if #(
  parameter int DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH
);
  import cau_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_re;
  logic signed [DATA_WIDTH-1:0] res_im;
  logic [ST_W-1:0]              status;
  logic                         last_out;

  modport source (output valid, res_re, res_im, status, last_out, input ready);
  modport sink   (input valid, res_re, res_im, status, last_out, output ready);

endinterface
`default_nettype wire

/* rtl/cau_div_cell.sv */
`default_nettype none
// One restoring-division step for both lanes: one quotient bit per cell.
module cau_div_cell #(
  parameter int RW = 65,
  parameter int QB = 33,
  parameter int TW = 73
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 v_i,
  input  logic [1:0][RW-1:0]   rem_i,
  input  logic [1:0][QB-1:0]   nq_i,
  input  logic [RW-2:0]        den_i,
  input  logic [TW-1:0]        tag_i,
  output logic                 v_o,
  output logic [1:0][RW-1:0]   rem_o,
  output logic [1:0][QB-1:0]   nq_o,
  output logic [RW-2:0]        den_o,
  output logic [TW-1:0]        tag_o
);

  logic [1:0][RW-1:0] t;
  logic [1:0]         ge;
  logic [1:0][RW-1:0] rem_nxt;
  logic [1:0][QB-1:0] nq_nxt;

  logic               v_r;
  logic [1:0][RW-1:0] rem_r;
  logic [1:0][QB-1:0] nq_r;
  logic [RW-2:0]      den_r;
  logic [TW-1:0]      tag_r;

  // nq holds the numerator bits still to come at the top, quotient bits at the bottom
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      t[l]       = {rem_i[l][RW-2:0], nq_i[l][QB-1]};
      ge[l]      = t[l] >= {1'b0, den_i};
      rem_nxt[l] = ge[l] ? t[l] - {1'b0, den_i} : t[l];
      nq_nxt[l]  = {nq_i[l][QB-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
      den_r <= den_i;
      tag_r <= tag_i;
    end
  end

  assign v_o   = v_r;
  assign rem_o = rem_r;
  assign nq_o  = nq_r;
  assign den_o = den_r;
  assign tag_o = tag_r;

endmodule
`default_nettype wire

/* rtl/complex_arithmetic_unit_core.sv */
`default_nettype none
// Complex arithmetic unit: x*y, x/y, x*c, x/c, x+y*c on signed fixed point.
// Pipeline from input transaction to result:
//   operand select, products, sums, divide prep, DATA_WIDTH+1 divide cells, output reg.
// Throughput: one transaction per cycle; the whole pipe holds while a result waits.
// Reset (rst_n, synchronous, active low) empties the pipe and sets c to 1.0 + 0i.
module complex_arithmetic_unit_core #(
  parameter int DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH,
  parameter int FRAC_BITS  = cau_pkg::CAU_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  cau_in_if.sink                        in_ch,
  cau_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [cau_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [DATA_WIDTH-1:0]         cfg_wdata
);
  import cau_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;          // product
  localparam int SW  = PW + 1;         // sum of two products
  localparam int VW  = SW + 1;         // x plus floored product
  localparam int NW  = SW + F;         // divide numerator after upscale
  localparam int DNW = PW;             // divisor |b|^2, unsigned
  localparam int QB  = W + 1;          // quotient bits worked out
  localparam int RW  = DNW + 1;        // partial remainder
  localparam int HW  = NW - QB;        // numerator bits above the quotient window
  localparam int CW  = (HW > DNW) ? HW : DNW;

  localparam logic [W-1:0]         ONE_Q = W'(1) << F;
  localparam logic [W-1:0]         MAXW  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]         MINW  = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [VW-1:0] MAXV  = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [VW-1:0] MINV  = ~MAXV;
  localparam logic [QB-1:0]        HALF  = {2'b01, {(W-1){1'b0}}};

  typedef struct packed {
    logic          is_div;
    logic          dz;
    logic [1:0]    neg;
    logic [1:0]    ovf;
    logic [W-1:0]  res_re;
    logic [W-1:0]  res_im;
    logic [ST_W-1:0] st;
    logic          last;
  } tag_t;

  localparam int TW = $bits(tag_t);

  // ---------------------------------------------------------------- config
  logic signed [W-1:0] const_re_r, const_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      const_re_r <= ONE_Q;
      const_im_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CONST_RE: const_re_r <= cfg_wdata;
        CFG_CONST_IM: const_im_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- pipe advance
  // Single enable: everything moves when the output register is free or drained.
  logic out_valid_r;
  logic en;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // ------------------------------------------------- stage 1: operand select
  // MAC runs y*c through the multiplier with x carried for the final add.
  cls_t                cls_nxt;
  logic signed [W-1:0] a_re_nxt, a_im_nxt, b_re_nxt, b_im_nxt;

  always_comb begin
    cls_nxt  = CLS_NONE;
    a_re_nxt = in_ch.x_re;
    a_im_nxt = in_ch.x_im;
    b_re_nxt = in_ch.y_re;
    b_im_nxt = in_ch.y_im;
    unique case (in_ch.action)
      ACT_MUL: cls_nxt = CLS_MUL;
      ACT_DIV: cls_nxt = CLS_DIV;
      ACT_MULC: begin
        cls_nxt  = CLS_MUL;
        b_re_nxt = const_re_r;
        b_im_nxt = const_im_r;
      end
      ACT_DIVC: begin
        cls_nxt  = CLS_DIV;
        b_re_nxt = const_re_r;
        b_im_nxt = const_im_r;
      end
      ACT_MAC: begin
        cls_nxt  = CLS_MAC;
        a_re_nxt = in_ch.y_re;
        a_im_nxt = in_ch.y_im;
        b_re_nxt = const_re_r;
        b_im_nxt = const_im_r;
      end
      default: cls_nxt = CLS_NONE;
    endcase
  end

  logic                v1_r;
  cls_t                cls1_r;
  logic signed [W-1:0] a_re1_r, a_im1_r, b_re1_r, b_im1_r, x_re1_r, x_im1_r;
  logic                last1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cls1_r  <= cls_nxt;
      a_re1_r <= a_re_nxt;
      a_im1_r <= a_im_nxt;
      b_re1_r <= b_re_nxt;
      b_im1_r <= b_im_nxt;
      x_re1_r <= in_ch.x_re;
      x_im1_r <= in_ch.x_im;
      last1_r <= in_ch.last_in;
    end
  end

  // ------------------------------------------------- stage 2: six products
  logic                 v2_r;
  cls_t                 cls2_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [W-1:0]  x_re2_r, x_im2_r;
  logic                 last2_r;

  // operands sign-extended to the product width; still W x W signed products
  always_ff @(posedge clk) begin
    if (en) begin
      p0_r    <= PW'(a_re1_r) * PW'(b_re1_r);
      p1_r    <= PW'(a_im1_r) * PW'(b_im1_r);
      p2_r    <= PW'(a_re1_r) * PW'(b_im1_r);
      p3_r    <= PW'(a_im1_r) * PW'(b_re1_r);
      p4_r    <= PW'(b_re1_r) * PW'(b_re1_r);
      p5_r    <= PW'(b_im1_r) * PW'(b_im1_r);
      cls2_r  <= cls1_r;
      x_re2_r <= x_re1_r;
      x_im2_r <= x_im1_r;
      last2_r <= last1_r;
    end
  end

  // ------------------------------------------------- stage 3: sums
  logic signed [SW-1:0] e0, e1, e2, e3;
  logic signed [SW-1:0] sum_re_nxt, sum_im_nxt;

  assign e0 = SW'(p0_r);
  assign e1 = SW'(p1_r);
  assign e2 = SW'(p2_r);
  assign e3 = SW'(p3_r);

  always_comb begin
    if (cls2_r == CLS_DIV) begin
      // x * conj(b)
      sum_re_nxt = e0 + e1;
      sum_im_nxt = e3 - e2;
    end else begin
      sum_re_nxt = e0 - e1;
      sum_im_nxt = e2 + e3;
    end
  end

  logic                 v3_r;
  cls_t                 cls3_r;
  logic signed [SW-1:0] sum_re3_r, sum_im3_r;
  logic [DNW-1:0]       den3_r;
  logic signed [W-1:0]  x_re3_r, x_im3_r;
  logic                 last3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_re3_r <= sum_re_nxt;
      sum_im3_r <= sum_im_nxt;
      den3_r    <= $unsigned(p4_r) + $unsigned(p5_r);
      cls3_r    <= cls2_r;
      x_re3_r   <= x_re2_r;
      x_im3_r   <= x_im2_r;
      last3_r   <= last2_r;
    end
  end

  // ------------------------- stage 4: finish multiply/MAC, set up the divide
  logic signed [SW-1:0] s4 [2];
  logic signed [W-1:0]  x4 [2];
  logic signed [SW-1:0] fl [2];
  logic signed [VW-1:0] vv [2];
  logic [1:0]           lsat;
  logic [W-1:0]         lres [2];
  logic [1:0]           neg4;
  logic [SW-1:0]        absn [2];
  logic [NW-1:0]        mag [2];
  logic [HW-1:0]        hi [2];
  logic [1:0]           ovf4;
  logic [1:0][RW-1:0]   rem0;
  logic [1:0][QB-1:0]   nq0;
  tag_t                 tag_nxt;

  assign s4[0] = sum_re3_r;
  assign s4[1] = sum_im3_r;
  assign x4[0] = x_re3_r;
  assign x4[1] = x_im3_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      fl[l] = s4[l] >>> F;
      if (cls3_r == CLS_MAC) begin
        vv[l] = VW'(x4[l]) + VW'(fl[l]);
      end else begin
        vv[l] = VW'(fl[l]);
      end
      lsat[l] = (vv[l] > MAXV) || (vv[l] < MINV);
      lres[l] = (vv[l] > MAXV) ? MAXW : ((vv[l] < MINV) ? MINW : vv[l][W-1:0]);
      // divide: sign/magnitude split, quotient above QB bits means overflow
      neg4[l] = s4[l][SW-1];
      absn[l] = neg4[l] ? -s4[l] : s4[l];
      mag[l]  = NW'(absn[l]) << F;
      hi[l]   = mag[l][NW-1:QB];
      ovf4[l] = CW'(hi[l]) >= CW'(den3_r);
      rem0[l] = RW'(hi[l]);
      nq0[l]  = mag[l][QB-1:0];
    end
  end

  always_comb begin
    tag_nxt        = '0;
    tag_nxt.is_div = (cls3_r == CLS_DIV);
    tag_nxt.dz     = (den3_r == '0);
    tag_nxt.neg    = neg4;
    tag_nxt.ovf    = ovf4;
    tag_nxt.last   = last3_r;
    tag_nxt.st     = ST_OK;
    if (cls3_r == CLS_MUL || cls3_r == CLS_MAC) begin
      tag_nxt.res_re = lres[0];
      tag_nxt.res_im = lres[1];
      tag_nxt.st     = (|lsat) ? ST_SAT : ST_OK;
    end
  end

  logic               v4_r;
  logic [1:0][RW-1:0] rem4_r;
  logic [1:0][QB-1:0] nq4_r;
  logic [DNW-1:0]     den4_r;
  tag_t               tag4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem4_r <= rem0;
      nq4_r  <= nq0;
      den4_r <= den3_r;
      tag4_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // ------------------------------------------------- divide cell chain
  logic               c_v   [QB+1];
  logic [1:0][RW-1:0] c_rem [QB+1];
  logic [1:0][QB-1:0] c_nq  [QB+1];
  logic [DNW-1:0]     c_den [QB+1];
  tag_t               c_tag [QB+1];

  assign c_v[0]   = v4_r;
  assign c_rem[0] = rem4_r;
  assign c_nq[0]  = nq4_r;
  assign c_den[0] = den4_r;
  assign c_tag[0] = tag4_r;

  for (genvar k = 0; k < QB; k++) begin : g_cell
    cau_div_cell #(
      .RW (RW),
      .QB (QB),
      .TW (TW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .v_i   (c_v[k]),
      .rem_i (c_rem[k]),
      .nq_i  (c_nq[k]),
      .den_i (c_den[k]),
      .tag_i (c_tag[k]),
      .v_o   (c_v[k+1]),
      .rem_o (c_rem[k+1]),
      .nq_o  (c_nq[k+1]),
      .den_o (c_den[k+1]),
      .tag_o (c_tag[k+1])
    );
  end

  // ------------------------------------------------- final: sign, saturate
  tag_t          tag_e;
  logic [1:0]    dsat;
  logic [W-1:0]  qw   [2];
  logic [W-1:0]  dres [2];
  logic [W-1:0]  res_re_nxt, res_im_nxt;
  logic [ST_W-1:0] st_nxt;

  assign tag_e = c_tag[QB];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qw[l]   = c_nq[QB][l][W-1:0];
      dsat[l] = tag_e.ovf[l] ||
                (tag_e.neg[l] ? (c_nq[QB][l] > HALF) : (c_nq[QB][l] >= HALF));
      if (dsat[l]) begin
        dres[l] = tag_e.neg[l] ? MINW : MAXW;
      end else begin
        dres[l] = tag_e.neg[l] ? -qw[l] : qw[l];
      end
    end
    if (!tag_e.is_div) begin
      res_re_nxt = tag_e.res_re;
      res_im_nxt = tag_e.res_im;
      st_nxt     = tag_e.st;
    end else if (tag_e.dz) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      st_nxt     = ST_DZ;
    end else begin
      res_re_nxt = dres[0];
      res_im_nxt = dres[1];
      st_nxt     = (|dsat) ? ST_SAT : ST_OK;
    end
  end

  logic [W-1:0]    res_re_r, res_im_r;
  logic [ST_W-1:0] st_r;
  logic            last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_v[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      st_r     <= st_nxt;
      last_r   <= tag_e.last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.res_re   = res_re_r;
  assign out_ch.res_im   = res_im_r;
  assign out_ch.status   = st_r;
  assign out_ch.last_out = last_r;

`ifndef SYNTH
  // divide by zero always comes with a zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_DZ) |-> (out_ch.res_re == '0 && out_ch.res_im == '0))
    else $error("divide-by-zero result not zero");

  // saturated status means at least one part sits on a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_SAT) |->
      (res_re_r == MAXW || res_re_r == MINW || res_im_r == MAXW || res_im_r == MINW))
    else $error("saturated status without a rail value");

  // no status code beyond divide-by-zero is produced
  a_st_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status == ST_OK || out_ch.status == ST_SAT ||
                      out_ch.status == ST_DZ))
    else $error("illegal status code");

  // an empty output register never blocks the input side
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with free output register");

  // a stalled pipe keeps its last stage untouched
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(c_v[QB]))
    else $error("divide chain moved during stall");
`endif

endmodule
`default_nettype wire

/* tb/complex_arithmetic_unit_core_tb.sv */
module complex_arithmetic_unit_core_tb;
  import cau_pkg::*;

  localparam int DW = CAU_DATA_WIDTH;
  localparam int FB = CAU_FRAC_BITS;
  localparam int PIPE_LAT = DW + 6;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic [ST_W-1:0]      st;
    logic                 last;
  } cau_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DW-1:0] cfg_wdata;

  cau_in_if  #(.DATA_WIDTH(DW)) in_ch ();
  cau_out_if #(.DATA_WIDTH(DW)) out_ch ();

  complex_arithmetic_unit_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Local copy of the constant c
  logic signed [DW-1:0] c_re, c_im;

  cau_res_t pending_results[$];
  int       n_errors;
  int       n_checked;
  bit       hold_off;     // long receiver stall request
  int       op_count[8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Timeout at %0t", $time);
    $display("Regression FAIL");
    $finish;
  end

  // Saturate a wide signed value to the data width; flags on clipping.
  function automatic logic signed [DW-1:0] clip(input logic signed [255:0] v,
                                                inout bit sat);
    logic signed [255:0] hi, lo;
    hi = (256'sd1 <<< (DW - 1)) - 1;
    lo = -(256'sd1 <<< (DW - 1));
    if (v > hi) begin
      sat = 1'b1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // Division truncating toward zero on magnitudes.
  function automatic logic signed [255:0] quot_trunc(input logic signed [255:0] n,
                                                     input logic signed [255:0] d);
    logic [255:0] an, ad, q;
    an = n[255] ? -n : n;
    ad = d[255] ? -d : d;
    q = an / ad;
    return (n[255] != d[255]) ? -$signed(q) : $signed(q);
  endfunction

  function automatic cau_res_t complex_result(
      input logic [ACT_W-1:0] act,
      input logic signed [DW-1:0] xr, xi, yr, yi,
      input logic lst);
    logic signed [255:0] ar, ai, br, bi, pr, pi, den;
    bit sat;
    cau_res_t r;
    sat = 1'b0;
    r = '0;
    r.last = lst;
    ar = xr;
    ai = xi;
    case (act)
      ACT_MULC, ACT_DIVC: begin
        br = c_re;
        bi = c_im;
      end
      ACT_MAC: begin
        br = $signed(256'(yr)) * c_re - $signed(256'(yi)) * c_im;
        bi = $signed(256'(yr)) * c_im + $signed(256'(yi)) * c_re;
      end
      default: begin
        br = yr;
        bi = yi;
      end
    endcase
    case (act)
      ACT_MUL, ACT_MULC: begin
        pr = ar * br - ai * bi;
        pi = ar * bi + ai * br;
        r.re = clip(pr >>> FB, sat);
        r.im = clip(pi >>> FB, sat);
      end
      ACT_DIV, ACT_DIVC: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.st = ST_DZ;
          return r;
        end
        pr = (ar * br + ai * bi) <<< FB;
        pi = (ai * br - ar * bi) <<< FB;
        r.re = clip(quot_trunc(pr, den), sat);
        r.im = clip(quot_trunc(pi, den), sat);
      end
      ACT_MAC: begin
        r.re = clip(ar + (br >>> FB), sat);
        r.im = clip(ai + (bi >>> FB), sat);
      end
      default: ;
    endcase
    r.st = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  // Receiver: random ready, plus the long hold-off when asked.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) out_ch.ready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) out_ch.ready <= 1'b1;
      else if ($urandom_range(0, 9) < 3)
        out_ch.ready <= ($urandom_range(0, 39) == 0) ? 1'b0 : ~out_ch.ready;
      else out_ch.ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      cau_res_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction re=%h im=%h st=%0d last=%b", $time,
                 out_ch.res_re, out_ch.res_im, out_ch.status, out_ch.last_out);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_ch.res_re !== want.re) begin
          $display("%0t: res_re expected %h actual %h", $time, want.re, out_ch.res_re);
          n_errors++;
        end
        if (out_ch.res_im !== want.im) begin
          $display("%0t: res_im expected %h actual %h", $time, want.im, out_ch.res_im);
          n_errors++;
        end
        if (out_ch.status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, out_ch.status);
          n_errors++;
        end
        if (out_ch.last_out !== want.last) begin
          $display("%0t: last_out expected %b actual %b", $time, want.last,
                   out_ch.last_out);
          n_errors++;
        end
      end
    end
  end

  // Send one transaction with an optional random gap before it.
  task automatic send_elem(input logic [ACT_W-1:0] act,
                           input logic signed [DW-1:0] xr, xi, yr, yi,
                           input logic lst, input bit gaps);
    int gap;
    gap = 0;
    if (gaps) begin
      if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
      if ($urandom_range(0, 49) == 0) gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.x_re    <= xr;
    in_ch.x_im    <= xi;
    in_ch.y_re    <= yr;
    in_ch.y_im    <= yi;
    in_ch.last_in <= lst;
    pending_results.push_back(complex_result(act, xr, xi, yr, yi, lst));
    op_count[act]++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  // Register writes happen only with the pipe empty.
  task automatic write_const(input logic signed [DW-1:0] re, input logic signed [DW-1:0] im);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_CONST_RE;
    cfg_wdata <= re;
    @(posedge clk);
    cfg_idx <= CFG_CONST_IM;
    cfg_wdata <= im;
    @(posedge clk);
    cfg_we <= 1'b0;
    c_re = re;
    c_im = im;
  endtask

  function automatic logic signed [DW-1:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $signed($urandom_range(0, 'h3ffff)) - 'sh20000;   // near +-2.0
      4: return $signed($urandom_range(0, 'hffffff)) - 'sh800000; // modest
      default: return $signed($urandom());
    endcase
  endfunction

  // Extremes, every operation, zero divisors, unused codes
  task automatic test_directed();
    logic signed [DW-1:0] mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    send_elem(ACT_MUL, 'sh10000, 'sh20000, 'sh30000, -'sh10000, 1'b0, 0);
    send_elem(ACT_MUL, mx, mx, mx, mx, 1'b1, 0);
    send_elem(ACT_MUL, mn, mn, mn, mn, 1'b0, 0);
    send_elem(ACT_MUL, -1, 0, 1, 0, 1'b0, 0);
    send_elem(ACT_DIV, 'sh10000, 0, 0, 0, 1'b1, 0);
    send_elem(ACT_DIV, mx, mn, 1, 0, 1'b0, 0);
    send_elem(ACT_DIV, -'sh30000, 'sh10000, 'sh20000, 0, 1'b0, 0);
    send_elem(ACT_DIV, mn, mn, mn, mn, 1'b1, 0);
    send_elem(ACT_MULC, mx, mn, 0, 0, 1'b0, 0);
    send_elem(ACT_DIVC, 'sh12345, -'sh6789, 0, 0, 1'b0, 0);
    send_elem(ACT_MAC, mx, mx, mx, 0, 1'b1, 0);
    send_elem(ACT_MAC, mn, mn, mn, mx, 1'b0, 0);
    send_elem(3'd5, 1, 2, 3, 4, 1'b1, 0);
    send_elem(3'd6, mx, mx, mx, mx, 1'b0, 0);
    send_elem(3'd7, mn, mn, mn, mn, 1'b1, 0);
    write_const(0, 0);   // zero constant: x/c divides by zero
    send_elem(ACT_DIVC, 'sh10000, 'sh10000, 0, 0, 1'b0, 0);
    send_elem(ACT_MULC, mx, mx, 0, 0, 1'b1, 0);
    send_elem(ACT_MAC, -'sh10000, 5, mx, mn, 1'b0, 0);
    write_const(mx, mn);
    send_elem(ACT_MULC, mn, mx, 0, 0, 1'b0, 0);
    send_elem(ACT_DIVC, mx, mx, 0, 0, 1'b1, 0);
    send_elem(ACT_MAC, 0, 0, mn, mn, 1'b0, 0);
    drain();
  endtask

  task automatic test_random(input int count);
    logic [ACT_W-1:0] act;
    for (int i = 0; i < count; i++) begin
      act = ($urandom_range(0, 19) == 0) ? ACT_W'($urandom_range(5, 7))
                                         : ACT_W'($urandom_range(0, 4));
      send_elem(act, rand_val(), rand_val(),
                ($urandom_range(0, 15) == 0) ? '0 : rand_val(),
                ($urandom_range(0, 15) == 0) ? '0 : rand_val(),
                ($urandom_range(0, 7) == 0), 1'b1);
    end
  endtask

  // Receiver stalls for a long stretch while items keep coming.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (PIPE_LAT * 3) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(150);
    join
  endtask

  initial begin
    n_errors = 0;
    n_checked = 0;
    hold_off = 1'b0;
    c_re = 32'sh10000;
    c_im = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.x_re = '0;
    in_ch.x_im = '0;
    in_ch.y_re = '0;
    in_ch.y_im = '0;
    in_ch.last_in = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(300);                  // constant c = max + j*min, as set at the end of the directed test
    test_backpressure();
    write_const($signed($urandom()), $signed($urandom()));
    test_random(400);
    write_const(32'sh80000000, 32'sh7fffffff);
    test_random(250);
    write_const($signed($urandom_range(0, 'h3ffff)) - 'sh20000,
                $signed($urandom_range(0, 'h3ffff)) - 'sh20000);
    test_random(500);
    drain();

    $display("Checked %0d results: mul %0d div %0d mulc %0d divc %0d mac %0d unused %0d",
             n_checked, op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
             op_count[5] + op_count[6] + op_count[7]);
    $display("Five constant settings incl. zero and extremes, long output stall exercised");
    if (n_errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
